/* rtl/nca_pkg.sv */
package nca_pkg;

  // Fixed field widths of the item, result and configuration channels
  localparam int COORD_INPUTS = 4;
  localparam int SLOT_W       = 4;
  localparam int CLUSTER_W    = 4;
  localparam int DIST_W       = 34;
  localparam int DIMS_W       = 3;
  localparam int CLUSTERS_W   = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Default sizing of the chain
  localparam int DEF_MAX_CLUSTERS   = 16;
  localparam int DEF_MAX_DIMENSIONS = 4;
  localparam int DEF_COORD_BITS     = 16;

  // Item control that travels down the chain
  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic [SLOT_W-1:0] slot;
  } item_ctrl_t;

  // Best match found so far for a classify item
  typedef struct packed {
    logic                 have;
    logic [CLUSTER_W-1:0] idx;
    logic [DIST_W-1:0]    distance;
  } best_t;

endpackage

/* rtl/nca_cell.sv */
module nca_cell
  import nca_pkg::*;
#(
  parameter int CELL_IDX   = 0,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int DIM_LIM    = DEF_MAX_DIMENSIONS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic [DIMS_W-1:0]                    eff_dims,
  input  logic [CLUSTERS_W-1:0]                eff_clusters,
  input  item_ctrl_t                           ctrl_i,
  input  best_t                                best_i,
  input  logic [DIM_LIM-1:0][COORD_BITS-1:0]   point_i,
  output item_ctrl_t                           ctrl_o,
  output best_t                                best_o,
  output logic [DIM_LIM-1:0][COORD_BITS-1:0]   point_o
);

  localparam int SQ_W   = 2 * (COORD_BITS + 1);
  localparam int WIDE_W = (SQ_W > DIST_W) ? SQ_W : DIST_W;
  localparam int SUM_W  = DIST_W + 2;
  localparam int CMP_W  = 9;

  // Centroid held by this cell
  logic [DIM_LIM-1:0][COORD_BITS-1:0] cen_r;

  // Stage A: squares registered with the item
  item_ctrl_t                         ctrl_a_r;
  best_t                              best_a_r;
  logic [DIM_LIM-1:0][COORD_BITS-1:0] point_a_r;
  logic [DIM_LIM-1:0][DIST_W-1:0]     sq_a_r;
  logic [DIM_LIM-1:0][DIST_W-1:0]     sq_nxt;

  // Stage B: updated best registered with the item
  item_ctrl_t                         ctrl_b_r;
  best_t                              best_b_r;
  logic [DIM_LIM-1:0][COORD_BITS-1:0] point_b_r;
  best_t                              best_nxt;

  logic              load_hit;
  logic              active;
  logic              take;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] sum_sat;

  assign load_hit = ctrl_i.valid && ctrl_i.is_load && (CMP_W'(ctrl_i.slot) == CMP_W'(CELL_IDX));
  assign active   = CMP_W'(CELL_IDX) < CMP_W'(eff_clusters);

  // Saturating square of each coordinate difference, unused dimensions give zero
  for (genvar d = 0; d < DIM_LIM; d++) begin : g_sq
    logic signed [COORD_BITS:0] diff;
    logic        [COORD_BITS:0] mag;
    logic        [SQ_W-1:0]     sq;
    logic        [WIDE_W-1:0]   wide;
    assign diff = $signed({point_i[d][COORD_BITS-1], point_i[d]})
                - $signed({cen_r[d][COORD_BITS-1], cen_r[d]});
    assign mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : (COORD_BITS+1)'(diff);
    assign sq   = SQ_W'(mag) * SQ_W'(mag);
    assign wide = WIDE_W'(sq);
    assign sq_nxt[d] = (DIMS_W'(d) >= eff_dims) ? '0 :
                       (wide > WIDE_W'(DIST_MAX)) ? DIST_MAX : wide[DIST_W-1:0];
  end

  // Sum the squares and compare against the best so far
  always_comb begin
    sum = '0;
    for (int d = 0; d < DIM_LIM; d++) begin
      sum = sum + SUM_W'(sq_a_r[d]);
    end
  end

  assign sum_sat = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  assign take    = active && (!best_a_r.have || (sum_sat < best_a_r.distance));

  always_comb begin
    best_nxt = best_a_r;
    if (take) begin
      best_nxt.have     = 1'b1;
      best_nxt.idx      = CLUSTER_W'(CELL_IDX);
      best_nxt.distance = sum_sat;
    end
  end

  // Advance item control through both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a_r <= '0;
      ctrl_b_r <= '0;
    end else if (adv) begin
      ctrl_a_r <= ctrl_i;
      ctrl_b_r <= ctrl_a_r;
    end
  end

  // Advance payload and capture a centroid when its load passes
  always_ff @(posedge clk) begin
    if (adv) begin
      best_a_r  <= best_i;
      point_a_r <= point_i;
      sq_a_r    <= sq_nxt;
      best_b_r  <= best_nxt;
      point_b_r <= point_a_r;
      if (load_hit) begin
        cen_r <= point_i;
      end
    end
  end

  assign ctrl_o  = ctrl_b_r;
  assign best_o  = best_b_r;
  assign point_o = point_b_r;

endmodule

/* rtl/nearest_centroid_assign_unit.sv */
// Nearest-centroid assignment for k-means. Load items (req_type 0) store a centroid
// in the cell that owns its slot; classify items (req_type 1) return the index and
// squared distance of the nearest centroid among the first clusters_in_use slots,
// the lower index winning ties. Items travel down a chain of MAX_CLUSTERS cells,
// each holding one centroid, with a squares stage and a sum-and-compare stage,
// and the result is registered after the last cell. A new item, load or classify,
// can be taken every cycle while the chain advances. A stall on the result side
// freezes the whole chain. Slots must be loaded before a classify compares them.
module nearest_centroid_assign_unit
  import nca_pkg::*;
#(
  parameter int MAX_CLUSTERS   = DEF_MAX_CLUSTERS,
  parameter int MAX_DIMENSIONS = DEF_MAX_DIMENSIONS,
  parameter int COORD_BITS     = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [SLOT_W-1:0]            in_centroid_slot,
  input  logic signed [COORD_BITS-1:0] in_coord_0,
  input  logic signed [COORD_BITS-1:0] in_coord_1,
  input  logic signed [COORD_BITS-1:0] in_coord_2,
  input  logic signed [COORD_BITS-1:0] in_coord_3,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [CLUSTER_W-1:0]         out_nearest_cluster,
  output logic [DIST_W-1:0]            out_min_distance
);

  localparam int DIM_LIM = (MAX_DIMENSIONS < COORD_INPUTS) ? MAX_DIMENSIONS : COORD_INPUTS;
  localparam int CMP_W   = 9;

  localparam logic REG_DIMS     = 1'b0;
  localparam logic REG_CLUSTERS = 1'b1;

  logic [DIMS_W-1:0]     dims_r;
  logic [CLUSTERS_W-1:0] clusters_r;
  logic [DIMS_W-1:0]     eff_dims;
  logic [CLUSTERS_W-1:0] eff_clusters;
  logic                  cfg_wr;

  logic                  adv;
  logic                  out_valid_r;
  logic [CLUSTER_W-1:0]  out_nearest_cluster_r;
  logic [DIST_W-1:0]     out_min_distance_r;

  logic [COORD_INPUTS-1:0][COORD_BITS-1:0]     in_coords;
  item_ctrl_t                                   ctrl_c  [MAX_CLUSTERS+1];
  best_t                                        best_c  [MAX_CLUSTERS+1];
  logic [MAX_CLUSTERS:0][DIM_LIM-1:0][COORD_BITS-1:0] point_c;

  // Register write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r     <= DIMS_W'(2);
      clusters_r <= CLUSTERS_W'(2);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DIMS:     dims_r     <= pwdata[DIMS_W-1:0];
        REG_CLUSTERS: clusters_r <= pwdata[CLUSTERS_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DIMS:     prdata = 32'(dims_r);
      REG_CLUSTERS: prdata = 32'(clusters_r);
      default:      prdata = '0;
    endcase
  end

  // Clamp the configured counts to between one and what the chain holds
  assign eff_dims = (dims_r == '0) ? DIMS_W'(1) :
                    (dims_r > DIMS_W'(DIM_LIM)) ? DIMS_W'(DIM_LIM) : dims_r;
  assign eff_clusters = (clusters_r == '0) ? CLUSTERS_W'(1) :
                        (CMP_W'(clusters_r) > CMP_W'(MAX_CLUSTERS)) ?
                        CLUSTERS_W'(MAX_CLUSTERS) : clusters_r;

  // Freeze the chain while a result waits and cannot move
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Feed the head of the chain
  assign in_coords = {in_coord_3, in_coord_2, in_coord_1, in_coord_0};

  assign ctrl_c[0].valid   = in_valid;
  assign ctrl_c[0].is_load = !in_req_type;
  assign ctrl_c[0].slot    = in_centroid_slot;
  assign best_c[0]         = '0;

  for (genvar d = 0; d < DIM_LIM; d++) begin : g_head
    assign point_c[0][d] = in_coords[d];
  end

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    nca_cell #(
      .CELL_IDX   (k),
      .COORD_BITS (COORD_BITS),
      .DIM_LIM    (DIM_LIM)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .eff_dims     (eff_dims),
      .eff_clusters (eff_clusters),
      .ctrl_i       (ctrl_c[k]),
      .best_i       (best_c[k]),
      .point_i      (point_c[k]),
      .ctrl_o       (ctrl_c[k+1]),
      .best_o       (best_c[k+1]),
      .point_o      (point_c[k+1])
    );
  end

  // Capture classify results at the tail, drop loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctrl_c[MAX_CLUSTERS].valid && !ctrl_c[MAX_CLUSTERS].is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_nearest_cluster_r <= best_c[MAX_CLUSTERS].idx;
      out_min_distance_r    <= best_c[MAX_CLUSTERS].distance;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_nearest_cluster = out_nearest_cluster_r;
  assign out_min_distance    = out_min_distance_r;

`ifndef SYNTH
  // A classify leaving the chain has matched at least one cell
  a_tail_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_c[MAX_CLUSTERS].valid && !ctrl_c[MAX_CLUSTERS].is_load)
      |-> best_c[MAX_CLUSTERS].have)
    else $error("classify reached the tail without a match");

  // The reported cluster lies within the slots in use
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (eff_clusters <= CLUSTERS_W'(1 << CLUSTER_W)))
      |-> (CLUSTERS_W'(out_nearest_cluster) < eff_clusters))
    else $error("nearest cluster outside the slots in use");

  // An accepted item is taken only while the chain advances
  a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while the chain is frozen");
`endif

endmodule

/* test/nearest_centroid_monitor.sv */
module nearest_centroid_monitor
  import nca_pkg::*;
#(
  parameter int   DIMS_ADDR     = 0,
  parameter int   CLUSTERS_ADDR = 4,
  parameter logic LOAD_CODE     = 1'b0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  input  logic                             pready,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [SLOT_W-1:0]                in_centroid_slot,
  input  logic signed [DEF_COORD_BITS-1:0] in_coord_0,
  input  logic signed [DEF_COORD_BITS-1:0] in_coord_1,
  input  logic signed [DEF_COORD_BITS-1:0] in_coord_2,
  input  logic signed [DEF_COORD_BITS-1:0] in_coord_3,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [CLUSTER_W-1:0]             out_nearest_cluster,
  input  logic [DIST_W-1:0]                out_min_distance,
  output int                               mismatch_count,
  output int                               assignments_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DEF_COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [DIST_W-1:0]    distance;
  } assignment_t;

  // Shadow copy of the centroid cells and the two registers
  coord_t                centroid_mem [DEF_MAX_CLUSTERS][COORD_INPUTS];
  logic [DIMS_W-1:0]     dims_reg;
  logic [CLUSTERS_W-1:0] clusters_reg;
  assignment_t           pending_assignments [$];

  // Scan the centroids in use and keep the first one at the smallest distance
  function automatic assignment_t nearest_centroid(input coord_t p0, input coord_t p1,
                                                   input coord_t p2, input coord_t p3);
    coord_t            pt [COORD_INPUTS];
    int                nd;
    int                nc;
    longint            diff;
    logic [DIST_W-1:0] sum;
    assignment_t       best;
    pt[0] = p0;
    pt[1] = p1;
    pt[2] = p2;
    pt[3] = p3;
    nd = (dims_reg == 0) ? 1 : int'(dims_reg);
    if (nd > DEF_MAX_DIMENSIONS) nd = DEF_MAX_DIMENSIONS;
    if (nd > COORD_INPUTS) nd = COORD_INPUTS;
    nc = (clusters_reg == 0) ? 1 : int'(clusters_reg);
    if (nc > DEF_MAX_CLUSTERS) nc = DEF_MAX_CLUSTERS;
    best = '0;
    for (int c = 0; c < nc; c++) begin
      sum = '0;
      for (int d = 0; d < nd; d++) begin
        diff = longint'(pt[d]) - longint'(centroid_mem[c][d]);
        sum  = sum + DIST_W'(diff * diff);
      end
      if (c == 0 || sum < best.distance) begin
        best.cluster  = CLUSTER_W'(c);
        best.distance = sum;
      end
    end
    return best;
  endfunction

  // Follow register writes and transfers on both channels
  always @(posedge clk) begin : track
    assignment_t due;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      pending_assignments.delete();
      dims_reg     = 2;
      clusters_reg = 2;
      for (int c = 0; c < DEF_MAX_CLUSTERS; c++)
        for (int d = 0; d < COORD_INPUTS; d++)
          centroid_mem[c][d] = '0;
      mismatch_count   <= 0;
      assignments_owed <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == DIMS_ADDR) dims_reg = pwdata[DIMS_W-1:0];
        else if (paddr == CLUSTERS_ADDR) clusters_reg = pwdata[CLUSTERS_W-1:0];
      end

      // A load overwrites its slot, a classify queues its expected assignment
      if (in_valid && !in_stall) begin
        if (in_req_type == LOAD_CODE) begin
          centroid_mem[in_centroid_slot][0] = in_coord_0;
          centroid_mem[in_centroid_slot][1] = in_coord_1;
          centroid_mem[in_centroid_slot][2] = in_coord_2;
          centroid_mem[in_centroid_slot][3] = in_coord_3;
        end else begin
          pending_assignments.insert(pending_assignments.size(),
            nearest_centroid(in_coord_0, in_coord_1, in_coord_2, in_coord_3));
        end
      end

      // Compare each result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (pending_assignments.size() == 0) begin
          $error("unexpected result: nearest_cluster %0d min_distance %0d",
                 out_nearest_cluster, out_min_distance);
          errs++;
        end else begin
          due = pending_assignments.pop_front();
          if (out_nearest_cluster !== due.cluster) begin
            $error("nearest_cluster: expected %0d, actual %0d",
                   due.cluster, out_nearest_cluster);
            errs++;
          end
          if (out_min_distance !== due.distance) begin
            $error("min_distance: expected %0d, actual %0d", due.distance,
                   out_min_distance);
            errs++;
          end
        end
      end
      mismatch_count   <= mismatch_count + errs;
      assignments_owed <= pending_assignments.size();
    end
  end

endmodule

/* test/testbench.sv */
module testbench;
  import nca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   DIMS_ADDR      = 0;
  localparam int   CLUSTERS_ADDR  = 4;
  localparam logic REQ_LOAD       = 1'b0;
  localparam logic REQ_CLASSIFY   = 1'b1;
  localparam int   PHASES         = 10;
  localparam int   PHASE_ITEMS    = 183;
  localparam int   CHAIN_LATENCY  = 2 * DEF_MAX_CLUSTERS + 1;
  localparam int   CYCLE_LIMIT    = 600000;

  typedef logic signed [DEF_COORD_BITS-1:0] coord_t;

  localparam coord_t C_MIN = coord_t'(-32768);
  localparam coord_t C_MAX = coord_t'(32767);

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_req_type;
  logic [SLOT_W-1:0]    in_centroid_slot;
  coord_t               in_coord_0;
  coord_t               in_coord_1;
  coord_t               in_coord_2;
  coord_t               in_coord_3;
  logic                 out_valid;
  logic                 out_stall;
  logic [CLUSTER_W-1:0] out_nearest_cluster;
  logic [DIST_W-1:0]    out_min_distance;

  int   mismatch_count;
  int   assignments_owed;
  int   cycle_count = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  logic quiet;

  nearest_centroid_assign_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_centroid_slot    (in_centroid_slot),
    .in_coord_0          (in_coord_0),
    .in_coord_1          (in_coord_1),
    .in_coord_2          (in_coord_2),
    .in_coord_3          (in_coord_3),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_nearest_cluster (out_nearest_cluster),
    .out_min_distance    (out_min_distance)
  );

  nearest_centroid_monitor #(
    .DIMS_ADDR     (DIMS_ADDR),
    .CLUSTERS_ADDR (CLUSTERS_ADDR),
    .LOAD_CODE     (REQ_LOAD)
  ) monitor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_centroid_slot    (in_centroid_slot),
    .in_coord_0          (in_coord_0),
    .in_coord_1          (in_coord_1),
    .in_coord_2          (in_coord_2),
    .in_coord_3          (in_coord_3),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_nearest_cluster (out_nearest_cluster),
    .out_min_distance    (out_min_distance),
    .mismatch_count      (mismatch_count),
    .assignments_owed    (assignments_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the result side in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Write one register: setup cycle, access cycle, then release the bus
  task automatic cfg_write(input int addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(addr);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Hold one item until it is transferred, then maybe drop valid for a while
  task automatic send_item(input logic req, input logic [SLOT_W-1:0] slot,
                           input coord_t c0, input coord_t c1,
                           input coord_t c2, input coord_t c3);
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_centroid_slot <= slot;
    in_coord_0       <= c0;
    in_coord_1       <= c1;
    in_coord_2       <= c2;
    in_coord_3       <= c3;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'(-32768);
      1:       return coord_t'(32767);
      2:       return coord_t'(0);
      3:       return coord_t'(-1);
      4, 5, 6: return coord_t'($urandom_range(0, 16)) - coord_t'(8);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Mostly classify, with loads reshuffling the centroids
  task automatic send_random_item();
    logic req;
    req = ($urandom_range(0, 3) == 0) ? REQ_LOAD : REQ_CLASSIFY;
    send_item(req, SLOT_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
              rand_coord());
  endtask

  // Let every outstanding result and any load still in the chain drain
  task automatic settle_chain();
    in_valid <= 1'b0;
    quiet    <= 1'b1;
    do @(posedge clk); while (assignments_owed != 0);
    repeat (CHAIN_LATENCY + 16) @(posedge clk);
  endtask

  initial begin : stimulus
    int dims_val;
    int clusters_val;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid         <= 1'b0;
    in_req_type      <= REQ_LOAD;
    in_centroid_slot <= '0;
    in_coord_0       <= '0;
    in_coord_1       <= '0;
    in_coord_2       <= '0;
    in_coord_3       <= '0;
    quiet            <= 1'b0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    rst_n            <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot first so no classify ever compares an unloaded centroid
    send_item(REQ_LOAD, 4'h0, C_MIN, C_MIN, C_MIN, C_MIN);
    send_item(REQ_LOAD, 4'h1, C_MAX, C_MAX, C_MAX, C_MAX);
    for (int s = 2; s < DEF_MAX_CLUSTERS; s++)
      send_item(REQ_LOAD, SLOT_W'(s), coord_t'(s * 4099 - 32768),
                coord_t'(s * 4099 + 7919), coord_t'(s * 1021 - 16384),
                coord_t'(-s * 2053));

    // Exact hits on the extremes, then the midpoint
    send_item(REQ_CLASSIFY, 4'hF, C_MIN, C_MIN, C_MIN, C_MIN);
    send_item(REQ_CLASSIFY, 4'h0, C_MAX, C_MAX, C_MAX, C_MAX);
    send_item(REQ_CLASSIFY, 4'hA, coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0));
    // Two equal centroids: the lower index wins
    send_item(REQ_LOAD, 4'h1, C_MIN, C_MIN, C_MIN, C_MIN);
    send_item(REQ_CLASSIFY, 4'h5, coord_t'(5), coord_t'(-5), coord_t'(7), coord_t'(7));
    send_item(REQ_LOAD, 4'h1, C_MAX, C_MAX, C_MAX, C_MAX);
    send_item(REQ_CLASSIFY, 4'h3, C_MIN, C_MAX, coord_t'(-1), coord_t'(0));

    // Random phases over a spread of register settings, extremes included
    for (int p = 0; p < PHASES; p++) begin
      settle_chain();
      case (p)
        0:       begin dims_val = 1; clusters_val = 1;  end
        1:       begin dims_val = 4; clusters_val = 16; end
        2:       begin dims_val = 0; clusters_val = 0;  end
        3:       begin dims_val = 7; clusters_val = 31; end
        4:       begin dims_val = 3; clusters_val = 5;  end
        5:       begin dims_val = 5; clusters_val = 17; end
        6:       begin dims_val = 2; clusters_val = 16; end
        7, 8:    begin
          dims_val     = $urandom_range(0, 7);
          clusters_val = $urandom_range(0, 31);
        end
        default: begin dims_val = 4; clusters_val = 16; end
      endcase
      cfg_write(DIMS_ADDR, ($urandom & ~32'h7) | 32'(dims_val));
      cfg_write(CLUSTERS_ADDR, ($urandom & ~32'h1F) | 32'(clusters_val));
      if (p == PHASES - 1) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        recv_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      quiet <= 1'b0;
      repeat (PHASE_ITEMS) send_random_item();
    end

    // Drain and deliver the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (assignments_owed != 0);
    repeat (CHAIN_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && assignments_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/nca_pkg.sv
rtl/nca_cell.sv
rtl/nearest_centroid_assign_unit.sv
test/nearest_centroid_monitor.sv
test/testbench.sv
